// ===== design/cteb_pkg.sv =====
package cteb_pkg;

  localparam int BUFFER_DEPTH = 256;
  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CW = $clog2(BUFFER_DEPTH + 1);

  localparam logic [2:0] OP_INSERT    = 3'd0;
  localparam logic [2:0] OP_BACKSPACE = 3'd1;
  localparam logic [2:0] OP_LEFT      = 3'd2;
  localparam logic [2:0] OP_RIGHT     = 3'd3;
  localparam logic [2:0] OP_READ      = 3'd4;

  localparam logic ST_DONE    = 1'b0;
  localparam logic ST_IGNORED = 1'b1;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic          re;
    logic [AW-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic       status;
    logic [8:0] text_length;
    logic [8:0] cursor;
    logic [7:0] read_char;
  } res_t;

endpackage

// ===== design/cursor_text_edit_buffer.sv =====
// Line edit buffer with a cursor over a text memory of BUFFER_DEPTH bytes
// with one read port and one write port. One item is worked on at a time,
// and in_stall_o is high while it is in progress. Cursor moves, an insert or
// backspace at the end of the text, and rejected operations go straight to
// the result state; a read passes through one memory read wait state. An
// insert or backspace inside the text shifts the bytes between cursor and
// end through the memory, one byte per cycle, then writes the last shifted
// byte; an insert then puts the new character at the cursor. Results sit in
// an output register, so the next item is taken while one waits. A second
// finished result holds the input until the first is taken.
module cursor_text_edit_buffer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] opcode_i,
  input  logic [7:0] char_value_i,
  input  logic [7:0] read_index_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       status_o,
  output logic [8:0] text_length_o,
  output logic [8:0] cursor_o,
  output logic [7:0] read_char_o
);

  cteb_pkg::mem_req_t mem_req;
  logic [7:0]         mem_rdata;
  logic               res_valid;
  logic               res_ready;
  cteb_pkg::res_t     res;
  cteb_pkg::res_t     out_q;
  logic               out_valid_q, out_valid_d;

  cteb_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  cteb_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .char_value_i (char_value_i),
    .read_index_i (read_index_i),
    .mem_req_o    (mem_req),
    .mem_rdata_i  (mem_rdata),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  assign res_ready   = !out_valid_q || !out_stall_i;
  assign out_valid_d = (res_valid && res_ready) || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_q.status;
  assign text_length_o = out_q.text_length;
  assign cursor_o      = out_q.cursor;
  assign read_char_o   = out_q.read_char;

endmodule

// ===== design/cteb_store.sv =====
module cteb_store (
  input  logic                clk_i,
  input  cteb_pkg::mem_req_t  req_i,
  output logic [7:0]          rdata_o
);

  logic [7:0] mem [cteb_pkg::BUFFER_DEPTH];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_o <= mem[req_i.raddr];
    end
  end

endmodule

// ===== design/cteb_ctrl.sv =====
module cteb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          opcode_i,
  input  logic [7:0]          char_value_i,
  input  logic [7:0]          read_index_i,
  output cteb_pkg::mem_req_t  mem_req_o,
  input  logic [7:0]          mem_rdata_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output cteb_pkg::res_t      res_o
);

  localparam int AW = cteb_pkg::AW;
  localparam int CW = cteb_pkg::CW;
  localparam logic [CW-1:0] DEPTH = CW'(cteb_pkg::BUFFER_DEPTH);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SHIFT  = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_PUTCH  = 3'd3;
  localparam logic [2:0] S_RDWAIT = 3'd4;
  localparam logic [2:0] S_RESULT = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] cursor_q, cursor_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic          pend_q, pend_d;
  logic [AW-1:0] pend_addr_q, pend_addr_d;
  logic          ins_q, ins_d;
  logic [7:0]    ch_q, ch_d;
  logic          status_q, status_d;
  logic [7:0]    rchar_q, rchar_d;

  logic          accept;
  logic          last;
  logic          idx_ok;
  logic [CW-1:0] count_m1;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign count_m1   = CW'(count_q - 1'b1);

  // read index must fall inside the held text and inside the store
  assign idx_ok = ({{CW{1'b0}}, read_index_i} < {8'd0, count_q}) &&
                  ({{CW{1'b0}}, read_index_i} < {8'd0, DEPTH});

  assign last = ins_q ? (ptr_q == AW'(cursor_q)) : (ptr_q == AW'(count_m1));

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    cursor_d    = cursor_q;
    ptr_d       = ptr_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    ins_d       = ins_q;
    ch_d        = ch_q;
    status_d    = status_q;
    rchar_d     = rchar_q;
    mem_req_o   = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          status_d = cteb_pkg::ST_IGNORED;
          rchar_d  = 8'd0;
          pend_d   = 1'b0;
          ch_d     = char_value_i;
          state_d  = S_RESULT;
          case (opcode_i)
            cteb_pkg::OP_INSERT: begin
              if (count_q < DEPTH) begin
                status_d = cteb_pkg::ST_DONE;
                if (cursor_q == count_q) begin
                  mem_req_o.we    = 1'b1;
                  mem_req_o.waddr = AW'(cursor_q);
                  mem_req_o.wdata = char_value_i;
                  count_d  = CW'(count_q + 1'b1);
                  cursor_d = CW'(cursor_q + 1'b1);
                end else begin
                  ins_d   = 1'b1;
                  ptr_d   = AW'(count_m1);
                  state_d = S_SHIFT;
                end
              end
            end
            cteb_pkg::OP_BACKSPACE: begin
              if (cursor_q != '0) begin
                status_d = cteb_pkg::ST_DONE;
                if (cursor_q == count_q) begin
                  count_d  = count_m1;
                  cursor_d = CW'(cursor_q - 1'b1);
                end else begin
                  ins_d   = 1'b0;
                  ptr_d   = AW'(cursor_q);
                  state_d = S_SHIFT;
                end
              end
            end
            cteb_pkg::OP_LEFT: begin
              if (cursor_q != '0) begin
                status_d = cteb_pkg::ST_DONE;
                cursor_d = CW'(cursor_q - 1'b1);
              end
            end
            cteb_pkg::OP_RIGHT: begin
              if (cursor_q < count_q) begin
                status_d = cteb_pkg::ST_DONE;
                cursor_d = CW'(cursor_q + 1'b1);
              end
            end
            cteb_pkg::OP_READ: begin
              if (idx_ok) begin
                status_d        = cteb_pkg::ST_DONE;
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = AW'(read_index_i);
                state_d         = S_RDWAIT;
              end
            end
            default: begin
              status_d = cteb_pkg::ST_IGNORED;
            end
          endcase
        end
      end
      S_SHIFT: begin
        // read one entry, write the previous one a place over
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = ptr_q;
        mem_req_o.we    = pend_q;
        mem_req_o.waddr = pend_addr_q;
        mem_req_o.wdata = mem_rdata_i;
        pend_d      = 1'b1;
        pend_addr_d = ins_q ? AW'(ptr_q + 1'b1) : AW'(ptr_q - 1'b1);
        if (last) begin
          state_d = S_DRAIN;
        end else begin
          ptr_d = ins_q ? AW'(ptr_q - 1'b1) : AW'(ptr_q + 1'b1);
        end
      end
      S_DRAIN: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = pend_addr_q;
        mem_req_o.wdata = mem_rdata_i;
        pend_d          = 1'b0;
        if (ins_q) begin
          state_d = S_PUTCH;
        end else begin
          count_d  = count_m1;
          cursor_d = CW'(cursor_q - 1'b1);
          state_d  = S_RESULT;
        end
      end
      S_PUTCH: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = AW'(cursor_q);
        mem_req_o.wdata = ch_q;
        count_d  = CW'(count_q + 1'b1);
        cursor_d = CW'(cursor_q + 1'b1);
        state_d  = S_RESULT;
      end
      S_RDWAIT: begin
        rchar_d = mem_rdata_i;
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_valid_o       = (state_q == S_RESULT);
  assign res_o.status      = status_q;
  assign res_o.text_length = 9'(count_q);
  assign res_o.cursor      = 9'(cursor_q);
  assign res_o.read_char   = rchar_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      cursor_q <= '0;
      pend_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      cursor_q <= cursor_d;
      pend_q   <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q       <= ptr_d;
    pend_addr_q <= pend_addr_d;
    ins_q       <= ins_d;
    ch_q        <= ch_d;
    status_q    <= status_d;
    rchar_q     <= rchar_d;
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH)
    else $error("text count past capacity");

  a_cursor_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= count_q)
    else $error("cursor past end of text");

  a_no_same_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_req_o.we && mem_req_o.re) |-> (mem_req_o.waddr != mem_req_o.raddr))
    else $error("read and write of one entry in one cycle");

  a_state_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_ready_i) |=> (res_valid_o && $stable(res_o)))
    else $error("result dropped while not taken");
`endif

endmodule

// ===== bench/cursor_text_edit_buffer_tb.sv =====
`timescale 1ns / 100ps

module cursor_text_edit_buffer_tb;

  localparam int         BUFFER_DEPTH = cteb_pkg::BUFFER_DEPTH;
  localparam logic [2:0] OP_INSERT    = cteb_pkg::OP_INSERT;
  localparam logic [2:0] OP_BACKSPACE = cteb_pkg::OP_BACKSPACE;
  localparam logic [2:0] OP_LEFT      = cteb_pkg::OP_LEFT;
  localparam logic [2:0] OP_RIGHT     = cteb_pkg::OP_RIGHT;
  localparam logic [2:0] OP_READ      = cteb_pkg::OP_READ;
  localparam logic       ST_DONE      = cteb_pkg::ST_DONE;
  localparam logic       ST_IGNORED   = cteb_pkg::ST_IGNORED;

  typedef cteb_pkg::res_t res_t;

  // opcodes with no operation behind them
  localparam logic [2:0] OP_SPARE_A = 3'd5;
  localparam logic [2:0] OP_SPARE_B = 3'd6;
  localparam logic [2:0] OP_SPARE_C = 3'd7;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = BUFFER_DEPTH + 40;

  typedef enum int {
    MIX_EDITS,
    FILL_TEXT,
    HOLD_FULL,
    ERASE_TEXT
  } edit_mode_e;

  typedef struct {
    logic [2:0] op;
    logic [7:0] ch;
    logic [7:0] idx;
    bit         typed;
    res_t       res;
  } edit_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [2:0] opcode_i;
  logic [7:0] char_value_i;
  logic [7:0] read_index_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic       status_o;
  logic [8:0] text_length_o;
  logic [8:0] cursor_o;
  logic [7:0] read_char_o;

  // mirror of the text held by the block
  logic [7:0] text_mirror [0:BUFFER_DEPTH-1];
  int         mirror_len;
  int         mirror_cur;

  res_t       pending_q [$];
  edit_row_t  edit_tab [$];
  int         err_cnt;
  int         cycle_cnt;
  bit         in_quiet;
  bit         out_quiet;

  cursor_text_edit_buffer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .char_value_i  (char_value_i),
    .read_index_i  (read_index_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .text_length_o (text_length_o),
    .cursor_o      (cursor_o),
    .read_char_o   (read_char_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic res_t apply_edit(input logic [2:0] op, input logic [7:0] ch,
                                      input logic [7:0] idx);
    res_t r;
    r.status    = ST_IGNORED;
    r.read_char = 8'd0;
    case (op)
      OP_INSERT: begin
        if (mirror_len < BUFFER_DEPTH) begin
          for (int i = mirror_len; i > mirror_cur; i--) text_mirror[i] = text_mirror[i-1];
          text_mirror[mirror_cur] = ch;
          mirror_cur++;
          mirror_len++;
          r.status = ST_DONE;
        end
      end
      OP_BACKSPACE: begin
        if (mirror_cur > 0) begin
          for (int i = mirror_cur - 1; i + 1 < mirror_len; i++) text_mirror[i] = text_mirror[i+1];
          mirror_cur--;
          mirror_len--;
          r.status = ST_DONE;
        end
      end
      OP_LEFT: begin
        if (mirror_cur > 0) begin
          mirror_cur--;
          r.status = ST_DONE;
        end
      end
      OP_RIGHT: begin
        if (mirror_cur < mirror_len) begin
          mirror_cur++;
          r.status = ST_DONE;
        end
      end
      OP_READ: begin
        if (int'(idx) < mirror_len) begin
          r.read_char = text_mirror[idx];
          r.status    = ST_DONE;
        end
      end
      default: ;
    endcase
    r.text_length = 9'(mirror_len);
    r.cursor      = 9'(mirror_cur);
    return r;
  endfunction

  function automatic edit_row_t edit_row(input logic [2:0] op, input logic [7:0] ch,
                                         input logic [7:0] idx, input bit typed,
                                         input logic st, input int len, input int cur,
                                         input logic [7:0] rd);
    edit_row_t e;
    e.op                = op;
    e.ch                = ch;
    e.idx               = idx;
    e.typed             = typed;
    e.res.status        = st;
    e.res.text_length   = 9'(len);
    e.res.cursor        = 9'(cur);
    e.res.read_char     = rd;
    return e;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic drive_edit(input logic [2:0] op, input logic [7:0] ch,
                            input logic [7:0] idx, input bit typed, input res_t typed_res);
    int   gap;
    res_t pred;
    if ($urandom_range(0, 31) == 0) in_quiet = !in_quiet;
    gap = in_quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    char_value_i <= ch;
    read_index_i <= idx;
    do @(posedge clk_i); while (in_stall_o);
    pred = apply_edit(op, ch, idx);
    pending_q.push_back(typed ? typed_res : pred);
    @(negedge clk_i);
  endtask

  // result side: random stall before each item, then wait for it
  initial begin
    int hold;
    out_stall_i = 1'b0;
    out_quiet   = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 31) == 0) out_quiet = !out_quiet;
      hold = out_quiet ? 0 : $urandom_range(0, 7);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected item status %0d length %0d cursor %0d char %0h",
                 $time, status_o, text_length_o, cursor_o, read_char_o);
        err_cnt++;
      end else begin
        want = pending_q.pop_front();
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, status_o);
          err_cnt++;
        end
        if (text_length_o !== want.text_length) begin
          $display("%0t: text_length expected %0d got %0d", $time, want.text_length,
                   text_length_o);
          err_cnt++;
        end
        if (cursor_o !== want.cursor) begin
          $display("%0t: cursor expected %0d got %0d", $time, want.cursor, cursor_o);
          err_cnt++;
        end
        if (read_char_o !== want.read_char) begin
          $display("%0t: read_char expected %0h got %0h", $time, want.read_char, read_char_o);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("cursor_text_edit_buffer regression: fail");
      $finish;
    end
  end

  initial begin
    edit_mode_e mode;
    int         steps;
    int         cap;
    int         pick;
    logic [2:0] op;
    logic [7:0] ch;
    logic [7:0] idx;
    res_t       none;

    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    opcode_i     = OP_INSERT;
    char_value_i = 8'd0;
    read_index_i = 8'd0;
    err_cnt      = 0;
    cycle_cnt    = 0;
    in_quiet     = 1'b0;
    mirror_len   = 0;
    mirror_cur   = 0;
    none         = '0;
    for (int i = 0; i < BUFFER_DEPTH; i++) text_mirror[i] = 8'd0;

    // empty buffer: everything but insert is rejected; then three inserts, reads and cursor moves
    edit_tab.push_back(edit_row(OP_BACKSPACE, 8'h00, 8'h00, 1, ST_IGNORED, 0, 0, 8'h00));
    edit_tab.push_back(edit_row(OP_LEFT,      8'h00, 8'h00, 1, ST_IGNORED, 0, 0, 8'h00));
    edit_tab.push_back(edit_row(OP_RIGHT,     8'h00, 8'h00, 1, ST_IGNORED, 0, 0, 8'h00));
    edit_tab.push_back(edit_row(OP_READ,      8'h00, 8'h00, 1, ST_IGNORED, 0, 0, 8'h00));
    edit_tab.push_back(edit_row(OP_READ,      8'hff, 8'hff, 1, ST_IGNORED, 0, 0, 8'h00));
    edit_tab.push_back(edit_row(OP_SPARE_A,   8'hff, 8'hff, 1, ST_IGNORED, 0, 0, 8'h00));
    edit_tab.push_back(edit_row(OP_SPARE_B,   8'h5a, 8'h00, 1, ST_IGNORED, 0, 0, 8'h00));
    edit_tab.push_back(edit_row(OP_SPARE_C,   8'hff, 8'hff, 1, ST_IGNORED, 0, 0, 8'h00));
    edit_tab.push_back(edit_row(OP_INSERT,    8'h00, 8'hff, 1, ST_DONE,    1, 1, 8'h00));
    edit_tab.push_back(edit_row(OP_INSERT,    8'hff, 8'h00, 1, ST_DONE,    2, 2, 8'h00));
    edit_tab.push_back(edit_row(OP_INSERT,    8'ha5, 8'h00, 1, ST_DONE,    3, 3, 8'h00));
    edit_tab.push_back(edit_row(OP_READ,      8'h00, 8'h00, 1, ST_DONE,    3, 3, 8'h00));
    edit_tab.push_back(edit_row(OP_READ,      8'h00, 8'h01, 1, ST_DONE,    3, 3, 8'hff));
    edit_tab.push_back(edit_row(OP_READ,      8'hff, 8'h02, 1, ST_DONE,    3, 3, 8'ha5));
    edit_tab.push_back(edit_row(OP_READ,      8'h00, 8'h03, 1, ST_IGNORED, 3, 3, 8'h00));
    edit_tab.push_back(edit_row(OP_RIGHT,     8'h00, 8'h00, 1, ST_IGNORED, 3, 3, 8'h00));
    edit_tab.push_back(edit_row(OP_LEFT,      8'h00, 8'h00, 1, ST_DONE,    3, 2, 8'h00));
    edit_tab.push_back(edit_row(OP_LEFT,      8'h00, 8'h00, 1, ST_DONE,    3, 1, 8'h00));
    // edits in the middle of the text
    edit_tab.push_back(edit_row(OP_INSERT,    8'h5a, 8'h00, 0, ST_DONE,    0, 0, 8'h00));
    edit_tab.push_back(edit_row(OP_READ,      8'h00, 8'h01, 0, ST_DONE,    0, 0, 8'h00));
    edit_tab.push_back(edit_row(OP_BACKSPACE, 8'h00, 8'h00, 0, ST_DONE,    0, 0, 8'h00));
    edit_tab.push_back(edit_row(OP_LEFT,      8'h00, 8'h00, 0, ST_DONE,    0, 0, 8'h00));
    edit_tab.push_back(edit_row(OP_BACKSPACE, 8'hff, 8'hff, 1, ST_IGNORED, 3, 0, 8'h00));
    edit_tab.push_back(edit_row(OP_RIGHT,     8'h00, 8'h00, 0, ST_DONE,    0, 0, 8'h00));
    edit_tab.push_back(edit_row(OP_READ,      8'h00, 8'h02, 0, ST_DONE,    0, 0, 8'h00));

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (edit_tab[k])
      drive_edit(edit_tab[k].op, edit_tab[k].ch, edit_tab[k].idx, edit_tab[k].typed,
                 edit_tab[k].res);

    // random edits: mixed, fill to full, work at full, erase, mixed again
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin mode = MIX_EDITS;  cap = 80;  end
        1: begin mode = FILL_TEXT;  cap = 600; end
        2: begin mode = HOLD_FULL;  cap = 20;  end
        3: begin mode = ERASE_TEXT; cap = 600; end
        default: begin mode = MIX_EDITS; cap = 40; end
      endcase
      steps = 0;
      while (steps < cap) begin
        if (mode == FILL_TEXT && mirror_len == BUFFER_DEPTH) break;
        if (mode == ERASE_TEXT && mirror_len <= 4) break;
        pick = $urandom_range(0, 99);
        ch   = 8'($urandom_range(0, 255));
        idx  = 8'($urandom_range(0, 255));
        case (mode)
          MIX_EDITS: begin
            if (pick < 35)      op = OP_INSERT;
            else if (pick < 50) op = OP_BACKSPACE;
            else if (pick < 62) op = OP_LEFT;
            else if (pick < 74) op = OP_RIGHT;
            else if (pick < 94) op = OP_READ;
            else                op = 3'($urandom_range(OP_SPARE_A, OP_SPARE_C));
          end
          FILL_TEXT: begin
            if (pick < 90)      op = OP_INSERT;
            else if (pick < 93) op = OP_LEFT;
            else if (pick < 96) op = OP_RIGHT;
            else if (pick < 99) op = OP_READ;
            else                op = OP_BACKSPACE;
          end
          HOLD_FULL: begin
            if (pick < 40)      op = OP_INSERT;
            else if (pick < 60) op = OP_READ;
            else if (pick < 80) op = OP_LEFT;
            else                op = OP_RIGHT;
          end
          default: begin
            if (pick < 80)      op = OP_BACKSPACE;
            else if (pick < 88) op = OP_LEFT;
            else if (pick < 94) op = OP_RIGHT;
            else                op = OP_READ;
          end
        endcase
        // reads mostly land inside the text
        if (op == OP_READ && mirror_len > 0 && $urandom_range(0, 4) != 0)
          idx = 8'($urandom_range(0, mirror_len - 1));
        drive_edit(op, ch, idx, 1'b0, none);
        steps++;
      end
    end

    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0)
      $display("cursor_text_edit_buffer regression: pass");
    else
      $display("cursor_text_edit_buffer regression: fail");
    $finish;
  end

endmodule
